/* hw/rtl/m3inv_pkg.sv */
package m3inv_pkg;

    localparam int ELEMS     = 9;
    localparam int COF_W     = 64;
    localparam int DET_W     = 98;
    localparam int DMAG_W    = 97;
    localparam int QBITS     = 33;
    localparam int REM_W     = DMAG_W + QBITS + 1;
    localparam int FRONT_LAT = 6;
    localparam int LANE_LAT  = QBITS + 2;

    typedef logic [ELEMS-1:0][31:0] t_mat;

    typedef struct packed {
        logic              singular;
        logic [DMAG_W-1:0] dmag;
    } t_det_info;

    // cofactor C[i] = a[A1]*a[A2] - a[B1]*a[B2], elements indexed row*3+col
    localparam logic [3:0] CF_A1 [ELEMS] = '{4'd4, 4'd5, 4'd3, 4'd2, 4'd0, 4'd1, 4'd1, 4'd2, 4'd0};
    localparam logic [3:0] CF_A2 [ELEMS] = '{4'd8, 4'd6, 4'd7, 4'd7, 4'd8, 4'd6, 4'd5, 4'd3, 4'd4};
    localparam logic [3:0] CF_B1 [ELEMS] = '{4'd5, 4'd3, 4'd4, 4'd1, 4'd2, 4'd0, 4'd2, 4'd0, 4'd1};
    localparam logic [3:0] CF_B2 [ELEMS] = '{4'd7, 4'd8, 4'd6, 4'd8, 4'd6, 4'd7, 4'd4, 4'd5, 4'd3};

    // output element row*3+col takes the transposed cofactor
    localparam logic [3:0] OUT_CF [ELEMS] = '{4'd0, 4'd3, 4'd6, 4'd1, 4'd4, 4'd7, 4'd2, 4'd5, 4'd8};

endpackage

/* hw/rtl/m3inv_front.sv */
module m3inv_front
    import m3inv_pkg::*;
(
    input  logic                  i_clk,
    input  t_mat                  i_elem,
    input  logic [15:0]           i_limit,
    output t_det_info             o_info,
    output logic [ELEMS-1:0][63:0] o_cmag,
    output logic [ELEMS-1:0]      o_neg
);

    logic signed [COF_W-1:0] r_pa [ELEMS];
    logic signed [COF_W-1:0] r_pb [ELEMS];
    logic signed [COF_W-1:0] r_cof2 [ELEMS];
    logic signed [COF_W-1:0] r_cof3 [ELEMS];
    logic signed [COF_W-1:0] r_cof4 [ELEMS];
    logic signed [COF_W-1:0] r_cof5 [ELEMS];
    logic signed [31:0]      r_col1 [3];
    logic signed [31:0]      r_col2 [3];
    logic signed [63:0]      r_ph [3];
    logic signed [64:0]      r_pl [3];
    logic signed [DET_W-1:0] r_term [3];
    logic signed [DET_W-1:0] r_det;
    t_det_info               r_info;
    logic [ELEMS-1:0][63:0]  r_cmag;
    logic [ELEMS-1:0]        r_neg;

    logic              dneg;
    logic [DET_W-1:0]  dneg_val;
    logic [DMAG_W-1:0] dmag;

    assign dneg     = r_det[DET_W-1];
    assign dneg_val = DET_W'(0) - DET_W'(r_det);
    assign dmag     = dneg ? dneg_val[DMAG_W-1:0] : r_det[DMAG_W-1:0];

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < ELEMS; i++) begin
            r_pa[i]   <= $signed(i_elem[CF_A1[i]]) * $signed(i_elem[CF_A2[i]]);
            r_pb[i]   <= $signed(i_elem[CF_B1[i]]) * $signed(i_elem[CF_B2[i]]);
            r_cof2[i] <= r_pa[i] - r_pb[i];
            r_cof3[i] <= r_cof2[i];
            r_cof4[i] <= r_cof3[i];
            r_cof5[i] <= r_cof4[i];
        end
        for (int k = 0; k < 3; k++) begin
            r_col1[k] <= $signed(i_elem[k*3]);
            r_col2[k] <= r_col1[k];
            // split the 64-bit cofactor into two 32-bit products
            r_ph[k]   <= r_col2[k] * $signed(r_cof2[k*3][63:32]);
            r_pl[k]   <= r_col2[k] * $signed({1'b0, r_cof2[k*3][31:0]});
            r_term[k] <= $signed({{2{r_ph[k][63]}}, r_ph[k], 32'b0})
                       + $signed({{33{r_pl[k][64]}}, r_pl[k]});
        end
        r_det <= r_term[0] + r_term[1] + r_term[2];

        r_info.dmag     <= dmag;
        r_info.singular <= dmag <= {49'b0, i_limit, 32'b0};
        for (int i = 0; i < ELEMS; i++) begin
            r_cmag[i] <= r_cof5[OUT_CF[i]][63] ? 64'(64'd0 - r_cof5[OUT_CF[i]])
                                              : r_cof5[OUT_CF[i]];
            r_neg[i]  <= (r_cof5[OUT_CF[i]][63] ^ dneg) && (r_cof5[OUT_CF[i]] != '0);
        end
    end

    assign o_info = r_info;
    assign o_cmag = r_cmag;
    assign o_neg  = r_neg;

endmodule

/* hw/rtl/m3inv_div_lane.sv */
module m3inv_div_lane
    import m3inv_pkg::*;
(
    input  logic              i_clk,
    input  logic [63:0]       i_cmag,
    input  logic              i_neg,
    input  logic [DMAG_W-1:0] i_dmag,
    output logic [31:0]       o_q
);

    logic [REM_W-1:0]  r_rem  [QBITS+1];
    logic [QBITS-1:0]  r_q    [QBITS+1];
    logic              r_ovf  [QBITS+1];
    logic              r_neg  [QBITS+1];
    logic [DMAG_W-1:0] r_dmag [QBITS+1];
    logic [31:0]       r_out;

    logic [REM_W-1:0] num;
    logic [REM_W-1:0] rem2;
    logic             up;
    logic [QBITS:0]   qf;

    assign num = {{(REM_W-64-32){1'b0}}, i_cmag, 32'b0};

    // quotient of 2^33 or more saturates either way
    always_ff @(posedge i_clk) begin
        r_rem[0]  <= num;
        r_q[0]    <= '0;
        r_ovf[0]  <= num >= {1'b0, i_dmag, {QBITS{1'b0}}};
        r_neg[0]  <= i_neg;
        r_dmag[0] <= i_dmag;
    end

    for (genvar k = 1; k <= QBITS; k++) begin : g_stage
        localparam int B = QBITS - k;
        logic [REM_W-1:0] dsh;
        logic             ge;
        assign dsh = {{(REM_W-DMAG_W){1'b0}}, r_dmag[k-1]} << B;
        assign ge  = r_rem[k-1] >= dsh;
        always_ff @(posedge i_clk) begin
            r_rem[k]    <= ge ? r_rem[k-1] - dsh : r_rem[k-1];
            r_q[k]      <= r_q[k-1] | (QBITS'(ge) << B);
            r_ovf[k]    <= r_ovf[k-1];
            r_neg[k]    <= r_neg[k-1];
            r_dmag[k]   <= r_dmag[k-1];
        end
    end

    // round half away from zero, then saturate
    assign rem2 = {r_rem[QBITS][REM_W-2:0], 1'b0};
    assign up   = rem2 >= {{(REM_W-DMAG_W){1'b0}}, r_dmag[QBITS]};
    assign qf   = {1'b0, r_q[QBITS]} + (QBITS+1)'(up);

    always_ff @(posedge i_clk) begin
        if (r_neg[QBITS]) begin
            if (r_ovf[QBITS] || qf > (QBITS+1)'(34'h080000000)) begin
                r_out <= 32'h8000_0000;
            end else begin
                r_out <= 32'd0 - qf[31:0];
            end
        end else begin
            if (r_ovf[QBITS] || qf > (QBITS+1)'(34'h07FFFFFFF)) begin
                r_out <= 32'h7FFF_FFFF;
            end else begin
                r_out <= qf[31:0];
            end
        end
    end

    assign o_q = r_out;

endmodule

/* hw/rtl/matrix3_inverse.sv */
// Throughput: one matrix per cycle; busy stays low, so start may be held every cycle.
// The 33-stage restoring divider in each of the nine lanes sets the latency.
// The receiver cannot stall: each result appears for exactly one cycle.
// Reset (synchronous, active low) empties the pipeline and sets near_zero_limit to 1.
module matrix3_inverse
    import m3inv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_near_zero_limit_we,
    input  logic [15:0] i_near_zero_limit,
    input  logic [31:0] i_in_r0c0,
    input  logic [31:0] i_in_r0c1,
    input  logic [31:0] i_in_r0c2,
    input  logic [31:0] i_in_r1c0,
    input  logic [31:0] i_in_r1c1,
    input  logic [31:0] i_in_r1c2,
    input  logic [31:0] i_in_r2c0,
    input  logic [31:0] i_in_r2c1,
    input  logic [31:0] i_in_r2c2,
    output logic        o_strobe,
    output logic [31:0] o_out_r0c0,
    output logic [31:0] o_out_r0c1,
    output logic [31:0] o_out_r0c2,
    output logic [31:0] o_out_r1c0,
    output logic [31:0] o_out_r1c1,
    output logic [31:0] o_out_r1c2,
    output logic [31:0] o_out_r2c0,
    output logic [31:0] o_out_r2c1,
    output logic [31:0] o_out_r2c2,
    output logic        o_invertible
);

    localparam int PIPE = FRONT_LAT + LANE_LAT;

    logic [15:0]            r_limit;
    logic [PIPE:0]          r_vld;
    t_mat                   r_pass [PIPE];
    logic                   r_sing [LANE_LAT];
    t_mat                   r_out;
    logic                   r_inv;

    t_mat                   elem;
    t_det_info              info;
    logic [ELEMS-1:0][63:0] cmag;
    logic [ELEMS-1:0]       neg;
    logic [ELEMS-1:0][31:0] q;

    assign busy = 1'b0;
    assign elem = {i_in_r2c2, i_in_r2c1, i_in_r2c0, i_in_r1c2, i_in_r1c1, i_in_r1c0,
                   i_in_r0c2, i_in_r0c1, i_in_r0c0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= 16'd1;
            r_vld   <= '0;
        end else begin
            if (i_near_zero_limit_we) begin
                r_limit <= i_near_zero_limit;
            end
            r_vld <= {r_vld[PIPE-1:0], start & ~busy};
        end
    end

    m3inv_front u_front (
        .i_clk   (i_clk),
        .i_elem  (elem),
        .i_limit (r_limit),
        .o_info  (info),
        .o_cmag  (cmag),
        .o_neg   (neg)
    );

    for (genvar i = 0; i < ELEMS; i++) begin : g_lane
        m3inv_div_lane u_lane (
            .i_clk  (i_clk),
            .i_cmag (cmag[i]),
            .i_neg  (neg[i]),
            .i_dmag (info.dmag),
            .o_q    (q[i])
        );
    end

    // hold the input and the singular flag alongside the lanes
    always_ff @(posedge i_clk) begin
        r_pass[0] <= elem;
        for (int s = 1; s < PIPE; s++) begin
            r_pass[s] <= r_pass[s-1];
        end
        r_sing[0] <= info.singular;
        for (int s = 1; s < LANE_LAT; s++) begin
            r_sing[s] <= r_sing[s-1];
        end
        r_out <= r_sing[LANE_LAT-1] ? r_pass[PIPE-1] : q;
        r_inv <= ~r_sing[LANE_LAT-1];
    end

    assign o_strobe     = r_vld[PIPE];
    assign o_out_r0c0   = r_out[0];
    assign o_out_r0c1   = r_out[1];
    assign o_out_r0c2   = r_out[2];
    assign o_out_r1c0   = r_out[3];
    assign o_out_r1c1   = r_out[4];
    assign o_out_r1c2   = r_out[5];
    assign o_out_r2c0   = r_out[6];
    assign o_out_r2c1   = r_out[7];
    assign o_out_r2c2   = r_out[8];
    assign o_invertible = r_inv;

endmodule

/* tb/matrix3_inverse_tb.sv */
`timescale 1ns / 1ps

class inverse_scoreboard;
    logic [8:0][31:0] exp_elems[$];
    logic             exp_inv[$];
    logic [15:0]      limit;
    int               errors;

    function new();
        limit  = 16'd1;
        errors = 0;
    endfunction

    function automatic logic signed [63:0] cofactor(logic signed [31:0] a1,
        logic signed [31:0] a2, logic signed [31:0] b1, logic signed [31:0] b2);
        logic signed [63:0] p;
        logic signed [63:0] q;
        p = a1 * a2;
        q = b1 * b2;
        return p - q;
    endfunction

    // round |c|*2^32/dmag, ties away from zero, then sign and saturate
    function automatic logic [31:0] divide_round(logic signed [63:0] c,
        logic [127:0] dmag, logic dneg);
        logic [63:0]  cm;
        logic [127:0] num;
        logic [127:0] quo;
        logic [127:0] rem;
        logic         neg;
        cm  = c[63] ? -c : c;
        neg = (c[63] != dneg) && (cm != 0);
        num = {32'd0, cm, 32'd0};
        quo = num / dmag;
        rem = num % dmag;
        if (rem >= dmag - rem) quo = quo + 1;
        if (!neg) return (quo > 128'h7FFFFFFF) ? 32'h7FFFFFFF : quo[31:0];
        if (quo > 128'h80000000) return 32'h80000000;
        return -quo[31:0];
    endfunction

    function void note_request(logic [8:0][31:0] m);
        logic signed [63:0]  cf[9];
        logic signed [127:0] det;
        logic [127:0]        dmag;
        logic [8:0][31:0]    res;
        int                  r, k;
        cf[0] = cofactor(m[4], m[8], m[5], m[7]);
        cf[1] = cofactor(m[5], m[6], m[3], m[8]);
        cf[2] = cofactor(m[3], m[7], m[4], m[6]);
        cf[3] = cofactor(m[2], m[7], m[1], m[8]);
        cf[4] = cofactor(m[0], m[8], m[2], m[6]);
        cf[5] = cofactor(m[1], m[6], m[0], m[7]);
        cf[6] = cofactor(m[1], m[5], m[2], m[4]);
        cf[7] = cofactor(m[2], m[3], m[0], m[5]);
        cf[8] = cofactor(m[0], m[4], m[1], m[3]);
        det = $signed(m[0]) * cf[0] + $signed(m[3]) * cf[3] + $signed(m[6]) * cf[6];
        dmag = det[127] ? -det : det;
        if (dmag <= {64'd0, 16'd0, limit, 32'd0}) begin
            exp_elems.push_back(m);
            exp_inv.push_back(1'b0);
        end else begin
            for (r = 0; r < 3; r++)
                for (k = 0; k < 3; k++)
                    res[r*3+k] = divide_round(cf[k*3+r], dmag, det[127]);
            exp_elems.push_back(res);
            exp_inv.push_back(1'b1);
        end
    endfunction

    task report(string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        errors++;
    endtask

    task check_result(logic [8:0][31:0] got, logic inv);
        logic [8:0][31:0] e;
        logic             ei;
        int               k;
        if (exp_elems.size() == 0) begin
            report("result with no pending request");
            return;
        end
        e  = exp_elems.pop_front();
        ei = exp_inv.pop_front();
        if (inv !== ei) report($sformatf("invertible got %b want %b", inv, ei));
        for (k = 0; k < 9; k++)
            if (got[k] !== e[k])
                report($sformatf("elem %0d got %h want %h", k, got[k], e[k]));
    endtask
endclass

module matrix3_inverse_tb;
    import m3inv_pkg::*;

    localparam int LATENCY   = FRONT_LAT + LANE_LAT + 1;
    localparam int WD_LIMIT  = 400;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    logic             i_near_zero_limit_we = 1'b0;
    logic [15:0]      i_near_zero_limit = '0;
    logic [8:0][31:0] mat = '0;
    logic             o_strobe;
    logic [8:0][31:0] res;
    logic             o_invertible;
    logic             no_idle = 1'b0;
    int               stall_left = 0;
    int               quiet_cycles = 0;

    inverse_scoreboard sb = new();

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    matrix3_inverse DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_near_zero_limit_we(i_near_zero_limit_we), .i_near_zero_limit(i_near_zero_limit),
        .i_in_r0c0(mat[0]), .i_in_r0c1(mat[1]), .i_in_r0c2(mat[2]),
        .i_in_r1c0(mat[3]), .i_in_r1c1(mat[4]), .i_in_r1c2(mat[5]),
        .i_in_r2c0(mat[6]), .i_in_r2c1(mat[7]), .i_in_r2c2(mat[8]),
        .o_strobe(o_strobe),
        .o_out_r0c0(res[0]), .o_out_r0c1(res[1]), .o_out_r0c2(res[2]),
        .o_out_r1c0(res[3]), .o_out_r1c1(res[4]), .o_out_r1c2(res[5]),
        .o_out_r2c0(res[6]), .o_out_r2c1(res[7]), .o_out_r2c2(res[8]),
        .o_invertible(o_invertible)
    );

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) sb.check_result(res, o_invertible);
        if (i_rst_n && ((start && !busy) || o_strobe)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WD_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic write_limit(logic [15:0] val);
        @(posedge i_clk);
        i_near_zero_limit_we <= 1'b1;
        i_near_zero_limit    <= val;
        sb.limit = val;
        @(posedge i_clk);
        i_near_zero_limit_we <= 1'b0;
    endtask

    // hold start low through an idle burst, then present one request
    task automatic send_request(logic [8:0][31:0] m);
        if (!no_idle && stall_left == 0 && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 9);
        while (stall_left > 0) begin
            start <= 1'b0;
            @(posedge i_clk);
            stall_left--;
        end
        start <= 1'b1;
        mat   <= m;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_request(m);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.exp_elems.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_elem(int kind);
        case (kind)
            0: return $urandom();
            1: return $urandom_range(0, 32'h3FFFF) - 32'h20000;
            2: return $urandom_range(0, 32'h7FF) - 32'h400;
            3: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
            default: return ($urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000);
        endcase
    endfunction

    task automatic random_requests(int count);
        logic [8:0][31:0] m;
        int               n, k, kind, pick;
        for (n = 0; n < count; n++) begin
            kind = $urandom_range(0, 4);
            for (k = 0; k < 9; k++)
                m[k] = ($urandom_range(0, 9) == 0) ? rand_elem($urandom_range(0, 4))
                                                    : rand_elem(kind);
            pick = $urandom_range(0, 9);
            // now and then make rows dependent, or thin out row 1, to hit the singular path
            if (pick == 0) begin
                m[6] = m[0]; m[7] = m[1]; m[8] = m[2];
            end else if (pick == 1) begin
                m[3] = m[3] & 32'h0000FFFF; m[4] = '0; m[5] = 32'h1;
            end
            send_request(m);
        end
    endtask

    logic [8:0][31:0] dm;
    int               k;

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: identity, scaled identity, zero, singular, extremes
        dm = '0; dm[0] = 32'h10000; dm[4] = 32'h10000; dm[8] = 32'h10000;
        send_request(dm);
        dm[0] = 32'h20000; dm[4] = 32'hFFFF8000; dm[8] = 32'h00004000;
        send_request(dm);
        send_request('0);
        for (k = 0; k < 9; k++) dm[k] = 32'h7FFFFFFF;
        send_request(dm);
        for (k = 0; k < 9; k++) dm[k] = 32'h80000000;
        send_request(dm);
        dm = '0; dm[0] = 32'h80000000; dm[4] = 32'h7FFFFFFF; dm[8] = 32'h80000000;
        send_request(dm);
        // tiny determinant: at or below the limit, so flagged singular
        dm = '0; dm[0] = 32'h1; dm[4] = 32'h1; dm[8] = 32'h10000;
        send_request(dm);
        dm = '0; dm[0] = 32'hFFFFFFFF; dm[4] = 32'h1; dm[8] = 32'h1;
        send_request(dm);
        // determinant exactly at the limit of one, then at twice it
        dm = '0; dm[0] = 32'h10000; dm[4] = 32'h10000; dm[8] = 32'h1;
        send_request(dm);
        dm[8] = 32'h2;
        send_request(dm);
        // rounding: 1/3 and -1/3
        dm = '0; dm[0] = 32'h30000; dm[4] = 32'h10000; dm[8] = 32'h10000;
        send_request(dm);
        dm[0] = 32'hFFFD0000;
        send_request(dm);
        dm = '0; dm[0] = 32'hFFFFFFFF; dm[4] = 32'hFFFFFFFF; dm[8] = 32'hFFFFFFFF;
        dm[1] = 32'h55555555; dm[5] = 32'hAAAAAAAA;
        send_request(dm);
        drain();

        write_limit(16'd0);
        dm = '0; dm[0] = 32'h1; dm[4] = 32'h1; dm[8] = 32'h1;
        send_request(dm);
        random_requests(450);
        drain();

        write_limit(16'hFFFF);
        random_requests(450);
        drain();

        write_limit(16'h5A5A);
        random_requests(450);
        drain();

        write_limit(16'd1);
        random_requests(300);
        no_idle = 1'b1;
        random_requests(200);
        drain();

        if (sb.errors == 0 && sb.exp_elems.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
